// ===== hw/rtl/ray_circle_exit_time_macros.svh =====
// Assertion macros shared by the ray-to-circle exit time RTL.
// Uses the aclk clock and aresetn reset of the including module.
`ifndef RAY_CIRCLE_EXIT_TIME_MACROS_SVH
`define RAY_CIRCLE_EXIT_TIME_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RCET_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RCET_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rcet_pkg.sv =====
// Shared widths, register indexes and sideband types for the exit time block.
// No dependencies; used by the square root, divider and top-level files.
package rcet_pkg;

    localparam int POS_W  = 32;
    localparam int VEL_W  = 24;
    localparam int RAD_W  = 31;
    localparam int A_W    = 48;   // |v|^2, units of 2^-32
    localparam int H_W    = 58;   // q.v signed, units of 2^-32
    localparam int D_W    = 114;  // discriminant, units of 2^-64
    localparam int ROOT_W = D_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int N_W    = 58;   // forward numerator, known positive
    localparam int FRAC_W = 16;
    localparam int TIME_W = 32;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] CFG_CENTRE_X = 2'd0;
    localparam logic [IDX_W-1:0] CFG_CENTRE_Y = 2'd1;
    localparam logic [IDX_W-1:0] CFG_RADIUS   = 2'd2;

    localparam logic [RAD_W-1:0] RADIUS_RESET = 31'd6553600;

    // Data that rides alongside the square root.
    typedef struct packed {
        logic                  zero;
        logic [A_W-1:0]        a;
        logic signed [H_W-1:0] h;
    } rcet_side_t;

    // Result overrides that ride alongside the divider.
    typedef struct packed {
        logic zero;
        logic sat;
    } rcet_flags_t;

endpackage

// ===== hw/rtl/ray_circle_exit_time.sv =====
// Ray-to-circle exit time: for each item (position, velocity) returns the forward time
// in Q16.16 seconds until the moving point reaches the configured circle, zero when the
// velocity is zero, the ray misses, or the root is not ahead, and all ones when too far.
// Depends on rcet_pkg, rcet_sqrt, rcet_div and ray_circle_exit_time_macros.svh.
//
// One item is accepted per cycle while s_tready is high. The path is 8 front-end stages,
// 57 square root stages, 2 numerator stages, 32 divider stages and the output register.
// The output register plus a skid entry let the pipeline keep taking items while a
// result waits; s_tready is a registered signal.
`include "ray_circle_exit_time_macros.svh"

module ray_circle_exit_time (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Configuration write port.
    input  logic                         cfg_we,
    input  logic [rcet_pkg::IDX_W-1:0]   cfg_index,
    input  logic [rcet_pkg::CFG_W-1:0]   cfg_wdata,
    // Input items.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [111:0]                 s_tdata,  // pos_x, pos_y, vel_x, vel_y
    // Result items.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata   // exit_time
);

    localparam int PW = rcet_pkg::POS_W;
    localparam int VW = rcet_pkg::VEL_W;
    localparam int AW = rcet_pkg::A_W;
    localparam int HW = rcet_pkg::H_W;
    localparam int DW = rcet_pkg::D_W;
    localparam int NW = rcet_pkg::N_W;
    localparam int FW = rcet_pkg::FRAC_W;
    localparam int TW = rcet_pkg::TIME_W;

    // Configuration registers.
    logic [PW-1:0]            cx_reg;
    logic [PW-1:0]            cy_reg;
    logic [rcet_pkg::RAD_W-1:0] radius_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            radius_reg <= rcet_pkg::RADIUS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                rcet_pkg::CFG_CENTRE_X: cx_reg     <= cfg_wdata;
                rcet_pkg::CFG_CENTRE_Y: cy_reg     <= cfg_wdata;
                rcet_pkg::CFG_RADIUS:   radius_reg <= cfg_wdata[rcet_pkg::RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline moves while the skid entry is empty.
    logic en;
    logic skid_valid_reg;
    logic out_valid_reg;
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    logic signed [PW-1:0] pos_x, pos_y;
    logic signed [VW-1:0] vel_x, vel_y;
    assign pos_x = s_tdata[31:0];
    assign pos_y = s_tdata[63:32];
    assign vel_x = s_tdata[87:64];
    assign vel_y = s_tdata[111:88];

    logic sq_valid;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg, v10_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; v4_reg <= 1'b0;
            v5_reg <= 1'b0; v6_reg <= 1'b0; v7_reg <= 1'b0; v8_reg <= 1'b0;
            v9_reg <= 1'b0; v10_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            v9_reg <= sq_valid;
            v10_reg <= v9_reg;
        end
    end

    // Stage 1: position relative to the centre.
    logic signed [PW:0]   qx_reg, qy_reg;
    logic signed [VW-1:0] vx_reg, vy_reg;
    // Stage 2: products.
    logic signed [2*PW+1:0]  pxx_reg, pyy_reg;
    logic signed [PW+VW:0]   pxv_reg, pyv_reg;
    logic signed [2*VW-1:0]  vxx_reg, vyy_reg;
    logic [2*rcet_pkg::RAD_W-1:0] rr2_reg, rr3_reg;
    // Stage 3: sums.
    logic [2*PW+1:0]      qq_reg;
    logic [AW-1:0]        a3_reg, a4_reg, a5_reg, a6_reg, a7_reg, a8_reg;
    logic signed [HW-1:0] h3_reg, h4_reg, h5_reg, h6_reg, h7_reg, h8_reg;
    // Stage 4: magnitudes of c and h.
    logic [2*PW+1:0]      cmag_reg;
    logic [HW-2:0]        habs_reg;
    logic                 cneg4_reg, cneg5_reg, cneg6_reg, cneg7_reg;
    logic                 z4_reg, z5_reg, z6_reg, z7_reg, z8_reg;
    // Stage 5: partial products.
    logic [45:0]          p00_reg, p10_reg, p20_reg, p01_reg, p11_reg, p21_reg;
    logic [57:0]          hll_reg;
    logic [56:0]          hlh_reg;
    logic [55:0]          hhh_reg;
    // Stages 6 to 8: assembled products and discriminant.
    logic [89:0]          ac0_reg, ac1_reg;
    logic [DW-1:0]        hsq6_reg, hsq7_reg, ac7_reg, d8_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            // Stage 1
            qx_reg <= $signed({pos_x[PW-1], pos_x}) - $signed({cx_reg[PW-1], cx_reg});
            qy_reg <= $signed({pos_y[PW-1], pos_y}) - $signed({cy_reg[PW-1], cy_reg});
            vx_reg <= vel_x;
            vy_reg <= vel_y;
            // Stage 2
            pxx_reg <= qx_reg * qx_reg;
            pyy_reg <= qy_reg * qy_reg;
            pxv_reg <= qx_reg * vx_reg;
            pyv_reg <= qy_reg * vy_reg;
            vxx_reg <= vx_reg * vx_reg;
            vyy_reg <= vy_reg * vy_reg;
            rr2_reg <= radius_reg * radius_reg;
            // Stage 3
            qq_reg  <= (2*PW+2)'(pxx_reg) + (2*PW+2)'(pyy_reg);
            a3_reg  <= AW'(vxx_reg) + AW'(vyy_reg);
            h3_reg  <= HW'(pxv_reg) + HW'(pyv_reg);
            rr3_reg <= rr2_reg;
            // Stage 4: c = |q|^2 - R^2 kept as sign and magnitude.
            cneg4_reg <= (qq_reg < (2*PW+2)'(rr3_reg));
            cmag_reg  <= (qq_reg < (2*PW+2)'(rr3_reg)) ? (2*PW+2)'(rr3_reg) - qq_reg
                                                       : qq_reg - (2*PW+2)'(rr3_reg);
            habs_reg  <= h3_reg[HW-1] ? (HW-1)'(-h3_reg) : (HW-1)'(h3_reg);
            z4_reg    <= (a3_reg == '0);
            a4_reg    <= a3_reg;
            h4_reg    <= h3_reg;
            // Stage 5: c*a in 22 by 24 pieces, h*h in 29 and 28 bit halves.
            p00_reg <= cmag_reg[21:0]  * a4_reg[23:0];
            p10_reg <= cmag_reg[43:22] * a4_reg[23:0];
            p20_reg <= cmag_reg[65:44] * a4_reg[23:0];
            p01_reg <= cmag_reg[21:0]  * a4_reg[47:24];
            p11_reg <= cmag_reg[43:22] * a4_reg[47:24];
            p21_reg <= cmag_reg[65:44] * a4_reg[47:24];
            hll_reg <= habs_reg[28:0]  * habs_reg[28:0];
            hlh_reg <= habs_reg[28:0]  * habs_reg[56:29];
            hhh_reg <= habs_reg[56:29] * habs_reg[56:29];
            cneg5_reg <= cneg4_reg;
            z5_reg    <= z4_reg;
            a5_reg    <= a4_reg;
            h5_reg    <= h4_reg;
            // Stage 6
            ac0_reg  <= 90'(p00_reg) + (90'(p10_reg) << 22) + (90'(p20_reg) << 44);
            ac1_reg  <= 90'(p01_reg) + (90'(p11_reg) << 22) + (90'(p21_reg) << 44);
            hsq6_reg <= DW'(hll_reg) + (DW'(hlh_reg) << 30) + (DW'(hhh_reg) << 58);
            cneg6_reg <= cneg5_reg;
            z6_reg    <= z5_reg;
            a6_reg    <= a5_reg;
            h6_reg    <= h5_reg;
            // Stage 7
            ac7_reg  <= DW'(ac0_reg) + (DW'(ac1_reg) << 24);
            hsq7_reg <= hsq6_reg;
            cneg7_reg <= cneg6_reg;
            z7_reg    <= z6_reg;
            a7_reg    <= a6_reg;
            h7_reg    <= h6_reg;
            // Stage 8: discriminant, negative one marks a miss.
            d8_reg <= cneg7_reg ? hsq7_reg + ac7_reg : hsq7_reg - ac7_reg;
            z8_reg <= z7_reg || (!cneg7_reg && (ac7_reg > hsq7_reg));
            a8_reg <= a7_reg;
            h8_reg <= h7_reg;
        end
    end

    // Square root of the discriminant.
    rcet_pkg::rcet_side_t        sq_side_in, sq_side;
    logic [rcet_pkg::ROOT_W-1:0] sq_root;

    assign sq_side_in = '{zero: z8_reg, a: a8_reg, h: h8_reg};

    rcet_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v8_reg),
        .in_rad    (d8_reg),
        .in_side   (sq_side_in),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // Numerator N = S - h and the saturation test.
    logic signed [NW:0] n_full;
    logic [NW-1:0]      n9_reg, n10_reg;
    logic [AW-1:0]      a9_reg, a10_reg;
    logic               z9_reg, z10_reg, sat10_reg;

    assign n_full = $signed((NW+1)'(sq_root)) - (NW+1)'(sq_side.h);

    always_ff @(posedge aclk) begin
        if (en) begin
            n9_reg    <= n_full[NW-1:0];
            z9_reg    <= sq_side.zero || n_full[NW] || (n_full == '0);
            a9_reg    <= sq_side.a;
            n10_reg   <= n9_reg;
            a10_reg   <= a9_reg;
            z10_reg   <= z9_reg;
            sat10_reg <= ((AW+FW)'(n9_reg) >= {a9_reg, FW'(0)});
        end
    end

    // Quotient floor(N * 2^16 / a).
    rcet_pkg::rcet_flags_t div_flags_in, div_flags;
    logic                  div_valid;
    logic [TW-1:0]         div_quot;

    assign div_flags_in = '{zero: z10_reg, sat: sat10_reg};

    rcet_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v10_reg),
        .in_num    (n10_reg),
        .in_den    (a10_reg),
        .in_flags  (div_flags_in),
        .out_valid (div_valid),
        .out_quot  (div_quot),
        .out_flags (div_flags)
    );

    logic [TW-1:0] res;
    assign res = div_flags.zero ? '0 : (div_flags.sat ? '1 : div_quot);

    // Output register with one skid entry behind it.
    logic [TW-1:0] out_data_reg, skid_data_reg;
    logic [TW-1:0] out_data_next, skid_data_next;
    logic          out_valid_next, skid_valid_next;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (div_valid) begin
            if (!out_valid_reg || m_tready) begin
                out_data_next  = res;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = res;
                skid_valid_next = 1'b1;
            end
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // The skid entry only fills behind a held result.
    `RCET_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid full with empty output")
    // A stalled result is never dropped.
    `RCET_ASSERT_NEXT(a_stall_keeps, m_tvalid && !m_tready, m_tvalid, "stalled result lost")
    // The skid entry drains only through a taken result.
    `RCET_ASSERT_NEXT(a_skid_holds, skid_valid_reg && !m_tready, skid_valid_reg, "skid item lost")

endmodule

// ===== hw/rtl/rcet_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Depends on rcet_pkg for widths and the sideband struct.
module rcet_sqrt (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [rcet_pkg::D_W-1:0]  in_rad,
    input  rcet_pkg::rcet_side_t      in_side,
    output logic                      out_valid,
    output logic [rcet_pkg::ROOT_W-1:0] out_root,
    output rcet_pkg::rcet_side_t      out_side
);

    localparam int RW = rcet_pkg::ROOT_W;
    localparam int MW = rcet_pkg::REM_W;

    logic                      vld_reg  [0:RW-1];
    logic [rcet_pkg::D_W-1:0]  rad_reg  [0:RW-1];
    logic [MW-1:0]             rem_reg  [0:RW-1];
    logic [RW-1:0]             root_reg [0:RW-1];
    rcet_pkg::rcet_side_t      side_reg [0:RW-1];

    genvar k;
    generate
        for (k = 0; k < RW; k++) begin : g_stage
            logic                     vld_prev;
            logic [rcet_pkg::D_W-1:0] rad_prev;
            logic [MW-1:0]            rem_prev;
            logic [RW-1:0]            root_prev;
            rcet_pkg::rcet_side_t     side_prev;
            logic [MW+1:0]            cand;
            logic [MW+1:0]            trial;
            logic                     ge;

            if (k == 0) begin : g_first
                assign vld_prev  = in_valid;
                assign rad_prev  = in_rad;
                assign rem_prev  = '0;
                assign root_prev = '0;
                assign side_prev = in_side;
            end else begin : g_next
                assign vld_prev  = vld_reg[k-1];
                assign rad_prev  = rad_reg[k-1];
                assign rem_prev  = rem_reg[k-1];
                assign root_prev = root_reg[k-1];
                assign side_prev = side_reg[k-1];
            end

            // Bring down the next two radicand bits and try a one in this root bit.
            assign cand  = {rem_prev, rad_prev[rcet_pkg::D_W-1-2*k -: 2]};
            assign trial = (MW+2)'({root_prev, 2'b01});
            assign ge    = (cand >= trial);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (en) begin
                    vld_reg[k] <= vld_prev;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rad_reg[k]  <= rad_prev;
                    rem_reg[k]  <= ge ? MW'(cand - trial) : MW'(cand);
                    root_reg[k] <= {root_prev[RW-2:0], ge};
                    side_reg[k] <= side_prev;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_side  = side_reg[RW-1];

endmodule

// ===== hw/rtl/rcet_div.sv =====
// Pipelined restoring divider: (n << 16) / a, one quotient bit per stage.
// Depends on rcet_pkg for widths and the flag struct.
module rcet_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [rcet_pkg::N_W-1:0]   in_num,
    input  logic [rcet_pkg::A_W-1:0]   in_den,
    input  rcet_pkg::rcet_flags_t      in_flags,
    output logic                       out_valid,
    output logic [rcet_pkg::TIME_W-1:0] out_quot,
    output rcet_pkg::rcet_flags_t      out_flags
);

    localparam int QW = rcet_pkg::TIME_W;
    localparam int AW = rcet_pkg::A_W;
    localparam int FW = rcet_pkg::FRAC_W;

    logic                  vld_reg  [0:QW-1];
    logic [AW-1:0]         rem_reg  [0:QW-1];
    logic [AW-1:0]         den_reg  [0:QW-1];
    logic [FW-1:0]         low_reg  [0:QW-1];
    logic [QW-1:0]         quot_reg [0:QW-1];
    rcet_pkg::rcet_flags_t flg_reg  [0:QW-1];

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_stage
            logic                  vld_prev;
            logic [AW-1:0]         rem_prev;
            logic [AW-1:0]         den_prev;
            logic [FW-1:0]         low_prev;
            logic [QW-1:0]         quot_prev;
            rcet_pkg::rcet_flags_t flg_prev;
            logic                  bit_in;
            logic [AW:0]           cand;
            logic                  ge;

            if (k == 0) begin : g_first
                // Upper numerator bits start the remainder; below a unless saturating.
                assign vld_prev  = in_valid;
                assign rem_prev  = AW'(in_num[rcet_pkg::N_W-1:FW]);
                assign den_prev  = in_den;
                assign low_prev  = in_num[FW-1:0];
                assign quot_prev = '0;
                assign flg_prev  = in_flags;
            end else begin : g_next
                assign vld_prev  = vld_reg[k-1];
                assign rem_prev  = rem_reg[k-1];
                assign den_prev  = den_reg[k-1];
                assign low_prev  = low_reg[k-1];
                assign quot_prev = quot_reg[k-1];
                assign flg_prev  = flg_reg[k-1];
            end

            // Low numerator bits feed in first, then the zeros of the fraction.
            if (k < FW) begin : g_num
                assign bit_in = low_prev[FW-1-k];
            end else begin : g_zero
                assign bit_in = 1'b0;
            end

            assign cand = {rem_prev, bit_in};
            assign ge   = (cand >= {1'b0, den_prev});

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (en) begin
                    vld_reg[k] <= vld_prev;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k]  <= ge ? AW'(cand - {1'b0, den_prev}) : AW'(cand);
                    den_reg[k]  <= den_prev;
                    low_reg[k]  <= low_prev;
                    quot_reg[k] <= {quot_prev[QW-2:0], ge};
                    flg_reg[k]  <= flg_prev;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[QW-1];
    assign out_quot  = quot_reg[QW-1];
    assign out_flags = flg_reg[QW-1];

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the ray-to-circle exit time block (ray_circle_exit_time).
// Needs rcet_pkg and the block's RTL; a scoreboard class predicts each exit time.
module tb;

    // Predicts exit times from the configured circle and holds them in order.
    class exit_time_board;
        logic [31:0] cen_x;
        logic [31:0] cen_y;
        logic [30:0] radius;
        logic [31:0] pending_times[$];
        int          errors;
        int          checked;

        function new();
            cen_x   = 0;
            cen_y   = 0;
            radius  = rcet_pkg::RADIUS_RESET;
            errors  = 0;
            checked = 0;
        endfunction

        // Mirror a register write; indexes without a register are dropped.
        function void write_reg(logic [rcet_pkg::IDX_W-1:0] idx,
                                logic [rcet_pkg::CFG_W-1:0] val);
            if (idx == rcet_pkg::CFG_CENTRE_X) cen_x = val;
            else if (idx == rcet_pkg::CFG_CENTRE_Y) cen_y = val;
            else if (idx == rcet_pkg::CFG_RADIUS) radius = val[30:0];
        endfunction

        // Exact integer solution of the forward root, floor sqrt and floor divide.
        function logic [31:0] exit_time(logic [111:0] d);
            logic signed [159:0] qx, qy, vx, vy, a, h, c, disc, root, cand, num, rr;
            qx = $signed(d[31:0]) - $signed(cen_x);
            qy = $signed(d[63:32]) - $signed(cen_y);
            vx = $signed(d[87:64]);
            vy = $signed(d[111:88]);
            rr = {129'd0, radius};
            a = vx * vx + vy * vy;
            if (a == 0) return 32'd0;
            h = qx * vx + qy * vy;
            c = qx * qx + qy * qy - rr * rr;
            disc = h * h - a * c;
            if (disc < 0) return 32'd0;
            root = 0;
            for (int b = 63; b >= 0; b--) begin
                cand = root | (160'sd1 <<< b);
                if (cand * cand <= disc) root = cand;
            end
            num = root - h;
            if (num <= 0) return 32'd0;
            if (num >= (a <<< 16)) return 32'hFFFF_FFFF;
            num = (num <<< 16) / a;
            return num[31:0];
        endfunction

        function void note_input(logic [111:0] d);
            pending_times.push_back(exit_time(d));
        endfunction

        function void check_result(logic [31:0] got);
            logic [31:0] want;
            if (pending_times.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_times.pop_front();
            checked++;
            if (got !== want) begin
                $display("%0t: exit_time mismatch, expected %h, actual %h", $time, want, got);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_times.size();
        endfunction
    endclass

    logic                         aclk;
    logic                         aresetn;
    logic                         cfg_we;
    logic [rcet_pkg::IDX_W-1:0]   cfg_index;
    logic [rcet_pkg::CFG_W-1:0]   cfg_wdata;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [111:0]                 s_tdata;   // pos_x, pos_y, vel_x, vel_y
    logic                         m_tvalid;
    logic                         m_tready;
    logic [31:0]                  m_tdata;   // exit_time

    exit_time_board board = new();
    int src_idle  = 0;
    int sink_idle = 0;
    int hold_cycles = 0;
    int sent = 0;

    ray_circle_exit_time uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial begin
        m_tready = 0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready = 0;
                hold_cycles--;
            end else begin
                m_tready = ($urandom_range(99) >= sink_idle);
            end
        end
    end

    // Results are checked at the rising edge they are accepted.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
    end

    // Offer one item, with random idle cycles first; returns at a falling edge.
    task automatic send_item(input logic [111:0] d);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid = 0;
            @(negedge aclk);
        end
        s_tvalid = 1;
        s_tdata  = d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_input(d);
        sent++;
        @(negedge aclk);
    endtask

    function automatic logic [111:0] pack_item(logic [31:0] px, logic [31:0] py,
                                               logic [23:0] vx, logic [23:0] vy);
        return {vy, vx, py, px};
    endfunction

    // Wait for every result, then let the pipeline settle.
    task automatic drain();
        s_tvalid = 0;
        while (board.outstanding() > 0) @(negedge aclk);
        repeat (120) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [rcet_pkg::IDX_W-1:0] idx,
                             input logic [rcet_pkg::CFG_W-1:0] val);
        cfg_we    = 1;
        cfg_index = idx;
        cfg_wdata = val;
        board.write_reg(idx, val);
        @(negedge aclk);
        cfg_we = 0;
    endtask

    // Random item: a quarter fully random, three quarters aimed around the circle with mixed speeds.
    function automatic logic [111:0] random_item();
        logic [31:0] px, py;
        logic [23:0] vx, vy;
        if ($urandom_range(3) == 0) begin
            px = $urandom;
            py = $urandom;
            vx = $urandom;
            vy = $urandom;
        end else begin
            px = board.cen_x + ($signed($urandom) >>> $urandom_range(31));
            py = board.cen_y + ($signed($urandom) >>> $urandom_range(31));
            vx = $signed($urandom) >>> (8 + $urandom_range(23));
            vy = $signed($urandom) >>> (8 + $urandom_range(23));
        end
        return pack_item(px, py, vx, vy);
    endfunction

    initial begin
        logic [31:0] one_m;
        aresetn   = 0;
        cfg_we    = 0;
        cfg_index = rcet_pkg::CFG_CENTRE_X;
        cfg_wdata = 0;
        s_tvalid  = 0;
        s_tdata   = 0;
        one_m     = 32'h0001_0000;
        repeat (10) @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        // Directed items against the reset circle of radius 100.
        send_item(pack_item(0, 0, 0, 0));                             // zero velocity
        send_item(pack_item(0, 0, 24'h010000, 0));                    // from centre, t = 100
        send_item(pack_item(0, 0, 0, 24'hFF0000));                    // moving down
        send_item(pack_item(200 * one_m, 0, 0, 24'h010000));          // misses the circle
        send_item(pack_item(200 * one_m, 0, 24'h010000, 0));          // root behind
        send_item(pack_item(-200 * one_m, 0, 24'h010000, 0));         // enters then exits
        send_item(pack_item(0, 100 * one_m, 24'h010000, 0));          // tangent point
        send_item(pack_item(0, 0, 24'h000001, 0));                    // too far, saturates
        send_item(pack_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'h7FFFFF, 24'h7FFFFF));
        send_item(pack_item(32'h8000_0000, 32'h8000_0000, 24'h800000, 24'h800000));
        send_item(pack_item(32'h7FFF_FFFF, 32'h8000_0000, 24'h800000, 24'h7FFFFF));
        send_item(pack_item(32'h8000_0000, 32'h7FFF_FFFF, 24'h7FFFFF, 24'h800000));
        send_item(pack_item(99 * one_m, 0, 24'h7FFFFF, 0));           // near the rim
        send_item(pack_item(0, 0, 24'hFFFFFF, 24'h000001));
        drain();

        // Index three has no register and must leave the circle alone.
        cfg_write(2'd3, 32'hFFFF_FFFF);
        send_item(pack_item(0, 0, 24'h010000, 0));
        drain();

        // Random phases, each under its own circle; the idling pattern changes every second phase.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    cfg_write(rcet_pkg::CFG_CENTRE_X, 0);
                    cfg_write(rcet_pkg::CFG_CENTRE_Y, 0);
                    cfg_write(rcet_pkg::CFG_RADIUS, 1);
                end
                1: begin
                    cfg_write(rcet_pkg::CFG_CENTRE_X, 32'h7FFF_FFFF);
                    cfg_write(rcet_pkg::CFG_CENTRE_Y, 32'h8000_0000);
                    cfg_write(rcet_pkg::CFG_RADIUS, 32'h7FFF_FFFF);
                end
                2: begin
                    cfg_write(rcet_pkg::CFG_CENTRE_X, 32'h8000_0000);
                    cfg_write(rcet_pkg::CFG_CENTRE_Y, 32'h7FFF_FFFF);
                    cfg_write(rcet_pkg::CFG_RADIUS, 32'd12345);
                end
                3: begin
                    cfg_write(rcet_pkg::CFG_CENTRE_X, $urandom);
                    cfg_write(rcet_pkg::CFG_CENTRE_Y, $urandom);
                    cfg_write(rcet_pkg::CFG_RADIUS, $urandom_range(32'h7FFF_FFFF, 1));
                end
                4: begin
                    // A radius of zero is computed as a point circle.
                    cfg_write(rcet_pkg::CFG_RADIUS, 0);
                end
                default: begin
                    cfg_write(rcet_pkg::CFG_CENTRE_X, 32'hFFFF_0000);
                    cfg_write(rcet_pkg::CFG_CENTRE_Y, 32'h0003_8000);
                    cfg_write(rcet_pkg::CFG_RADIUS, rcet_pkg::RADIUS_RESET);
                end
            endcase
            if (ph < 2) begin
                src_idle = 12; sink_idle = 47;
            end else if (ph < 4) begin
                src_idle = 47; sink_idle = 12;
            end else begin
                src_idle = 0; sink_idle = 0;
            end
            for (int i = 0; i < 172; i++) begin
                if (ph == 0 && i == 20) hold_cycles = 400;
                if (ph == 1 && i == 80) begin
                    s_tvalid = 0;
                    while (board.outstanding() > 0) @(negedge aclk);
                end
                send_item(random_item());
            end
            drain();
        end

        $display("Sent %0d items over seven circle settings, %0d results checked.",
                 sent, board.checked);
        $display("Covered degenerate, missing, behind, saturating and extreme-field items.");
        if (board.errors == 0 && board.outstanding() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("Some tests failed");
        $finish;
    end
endmodule
